// ===== rtl/hash_table_u32_open_addressing_core_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef HASH_TABLE_U32_OPEN_ADDRESSING_CORE_MACROS_SVH
`define HASH_TABLE_U32_OPEN_ADDRESSING_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HTOA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HTOA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/htoa_pkg.sv =====
package htoa_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned SCAN_W  = 11;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned USED_W  = 11;

  localparam logic [KEY_W-1:0]  KEY_EMPTY = 32'h0000_0000;
  localparam logic [KEY_W-1:0]  KEY_GONE  = 32'hFFFF_FFFF;
  localparam logic [USED_W-1:0] USED_MAX  = 11'h7FF;

  localparam logic [3:0] MIN_TABLE_BITS   = 4'd6;
  localparam logic [3:0] RESET_TABLE_BITS = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_FIND   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SCAN   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_DELETED  = 3'd4,
    ST_FULL     = 3'd5,
    ST_CLEARED  = 3'd6,
    ST_RESERVED = 3'd7
  } status_e;

  // What the controller does with a freshly offered item.
  typedef enum logic [1:0] {
    KIND_PROBE,
    KIND_SCAN,
    KIND_CLEAR,
    KIND_DIRECT
  } kind_e;

  typedef enum logic [2:0] {
    S_SWEEP_INIT,
    S_IDLE,
    S_HASH_A,
    S_HASH_B,
    S_HASH_C,
    S_PROBE,
    S_CLEAR,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] entry_data;
    logic [SCAN_W-1:0] scan_from;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DATA_W-1:0] data_out;
    logic [KEY_W-1:0]  key_out;
    logic [SLOT_W-1:0] slot_index;
    logic [USED_W-1:0] used_count;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic hash_a;
    logic hash_b;
    logic hash_c;
    logic probe;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  done;
    logic  sweep_last;
    logic  out_free;
  } stat_t;

endpackage

// ===== rtl/hash_table_u32_open_addressing_core.sv =====
// Channel   Handshake                  Payload
// in        in_valid_i / in_stall_o    in_item_i  (opcode, key, entry_data, scan_from)
// out       out_valid_o / out_stall_i  out_item_o (status, data_out, key_out, slot_index,
//                                                  used_count)
// cfg       APB write/read, pready=1   table_bits_in_use at byte address 0
//
// Find, insert, delete: accept, three key mix steps (hash A, B, C), then the
//   probe with one slot read per cycle, then finish; the single read port of
//   the key memory sets the probe pace.
// Scan: accept, probe, finish. Clear: every slot of the store emptied, one
//   per cycle. Reserved key, unused opcodes, out-of-range scan: straight to finish.
// After reset every slot of the key memory is swept empty; in_stall_o
//   stays high meanwhile, config writes are taken as usual.
// A held output transfer does not block the next item until its finish cycle.
module hash_table_u32_open_addressing_core #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  htoa_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htoa_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  htoa_pkg::cmd_t  cmd;
  htoa_pkg::stat_t stat;
  logic [3:0]      tbl_bits_q;
  logic            cfg_wr;

  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : {28'h0, tbl_bits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_bits_q <= htoa_pkg::RESET_TABLE_BITS;
    end else if (cfg_wr) begin
      tbl_bits_q <= pwdata[3:0];
    end
  end

  htoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  htoa_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .tbl_bits_i  (tbl_bits_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/htoa_ctrl.sv =====
module htoa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  htoa_pkg::stat_t stat_i,
  output htoa_pkg::cmd_t  cmd_o
);

  htoa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= htoa_pkg::S_SWEEP_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htoa_pkg::S_SWEEP_INIT: begin
        if (stat_i.sweep_last) state_d = htoa_pkg::S_IDLE;
      end
      htoa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (stat_i.kind)
            htoa_pkg::KIND_PROBE:  state_d = htoa_pkg::S_HASH_A;
            htoa_pkg::KIND_SCAN:   state_d = htoa_pkg::S_PROBE;
            htoa_pkg::KIND_CLEAR:  state_d = htoa_pkg::S_CLEAR;
            htoa_pkg::KIND_DIRECT: state_d = htoa_pkg::S_FINISH;
            default:               state_d = htoa_pkg::S_FINISH;
          endcase
        end
      end
      htoa_pkg::S_HASH_A: state_d = htoa_pkg::S_HASH_B;
      htoa_pkg::S_HASH_B: state_d = htoa_pkg::S_HASH_C;
      htoa_pkg::S_HASH_C: state_d = htoa_pkg::S_PROBE;
      htoa_pkg::S_PROBE: begin
        if (stat_i.done) state_d = htoa_pkg::S_FINISH;
      end
      htoa_pkg::S_CLEAR: begin
        if (stat_i.sweep_last) state_d = htoa_pkg::S_FINISH;
      end
      htoa_pkg::S_FINISH: begin
        // hold until the output register can take the result
        if (stat_i.out_free) state_d = htoa_pkg::S_IDLE;
      end
      default: state_d = htoa_pkg::S_SWEEP_INIT;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = (state_q == htoa_pkg::S_IDLE) && in_valid_i;
    cmd_o.sweep  = (state_q == htoa_pkg::S_SWEEP_INIT) || (state_q == htoa_pkg::S_CLEAR);
    cmd_o.hash_a = (state_q == htoa_pkg::S_HASH_A);
    cmd_o.hash_b = (state_q == htoa_pkg::S_HASH_B);
    cmd_o.hash_c = (state_q == htoa_pkg::S_HASH_C);
    cmd_o.probe  = (state_q == htoa_pkg::S_PROBE);
    cmd_o.finish = (state_q == htoa_pkg::S_FINISH);
    in_stall_o   = (state_q != htoa_pkg::S_IDLE);
  end

endmodule

// ===== rtl/htoa_datapath.sv =====
module htoa_datapath #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htoa_pkg::cmd_t      cmd_i,
  output htoa_pkg::stat_t     stat_o,
  input  htoa_pkg::in_item_t  in_item_i,
  input  logic [3:0]          tbl_bits_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output htoa_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned FW = (CW > htoa_pkg::SCAN_W) ? CW : htoa_pkg::SCAN_W;

  // Integer mix of the key, cut into three register-to-register steps.
  function automatic logic [31:0] mix_a(input logic [31:0] k);
    logic [31:0] t;
    t = ~k + (k << 15);
    return t ^ (t >> 12);
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] k);
    logic [31:0] t;
    t = k + (k << 2);
    return t ^ (t >> 4);
  endfunction

  function automatic logic [31:0] mix_c(input logic [31:0] k);
    logic [31:0] t;
    t = k + (k << 3) + (k << 11);
    return t ^ (t >> 16);
  endfunction

  logic [htoa_pkg::KEY_W-1:0]  key_mem [TABLE_DEPTH];
  logic [htoa_pkg::DATA_W-1:0] data_mem [TABLE_DEPTH];

  logic [htoa_pkg::OP_W-1:0]   op_q;
  logic                        rsv_q;
  logic [htoa_pkg::KEY_W-1:0]  key_q;
  logic [htoa_pkg::DATA_W-1:0] dat_q;
  logic [31:0]                 h_q;
  logic [AW-1:0]               idx_q;
  logic [CW-1:0]               step_q;
  logic                        issue_done_q;
  logic                        rd_vld_q, rd_last_q;
  logic [AW-1:0]               rd_idx_q;
  logic [htoa_pkg::KEY_W-1:0]  key_rd_q;
  logic [htoa_pkg::DATA_W-1:0] data_rd_q;
  logic                        hit_q, gone_ok_q, empty_ok_q;
  logic [AW-1:0]               hit_at_q, gone_at_q, empty_at_q;
  logic [htoa_pkg::DATA_W-1:0] hit_data_q;
  logic [htoa_pkg::KEY_W-1:0]  hit_key_q;
  logic [AW-1:0]               clr_idx_q;
  logic [htoa_pkg::USED_W-1:0] used_q, used_d;
  logic                        out_valid_q;
  htoa_pkg::out_item_t         out_item_q, res;

  logic [4:0]                  eff_bits;
  logic [AW-1:0]               mask;
  logic [CW-1:0]               cap;
  logic [31:0]                 hc;
  logic                        in_rsv, in_low, in_scan_ok;
  htoa_pkg::kind_e             in_kind;
  logic                        is_scan, k_empty, k_gone, k_match;
  logic                        done_now, found_now, empty_now, gone_now;
  logic                        issue, issue_last;
  logic [AW-1:0]               idx_next;
  logic                        fin, out_free;
  logic                        key_we, dat_we;
  logic [AW-1:0]               key_wa, dat_wa, ins_at;
  logic [htoa_pkg::KEY_W-1:0]  key_wd;

  // Capacity in use: at least 64 slots, at most the store depth.
  always_comb begin
    eff_bits = 5'(tbl_bits_i);
    if (tbl_bits_i < htoa_pkg::MIN_TABLE_BITS) eff_bits = 5'(htoa_pkg::MIN_TABLE_BITS);
    if (eff_bits > 5'(AW)) eff_bits = 5'(AW);
  end

  assign mask = ~({AW{1'b1}} << eff_bits);
  assign cap  = CW'(1) << eff_bits;
  assign hc   = mix_c(h_q);

  // Sort the offered item.
  assign in_rsv     = (in_item_i.key == htoa_pkg::KEY_EMPTY) ||
                      (in_item_i.key == htoa_pkg::KEY_GONE);
  assign in_low     = (in_item_i.opcode <= htoa_pkg::OP_DELETE);
  assign in_scan_ok = FW'(in_item_i.scan_from) < FW'(cap);

  always_comb begin
    priority if (in_low && in_rsv) begin
      in_kind = htoa_pkg::KIND_DIRECT;
    end else if (in_low) begin
      in_kind = htoa_pkg::KIND_PROBE;
    end else if (in_item_i.opcode == htoa_pkg::OP_CLEAR) begin
      in_kind = htoa_pkg::KIND_CLEAR;
    end else if (in_item_i.opcode == htoa_pkg::OP_SCAN && in_scan_ok) begin
      in_kind = htoa_pkg::KIND_SCAN;
    end else begin
      in_kind = htoa_pkg::KIND_DIRECT;
    end
  end

  // Evaluate the slot read in the previous cycle.
  assign is_scan = (op_q == htoa_pkg::OP_SCAN);
  assign k_empty = (key_rd_q == htoa_pkg::KEY_EMPTY);
  assign k_gone  = (key_rd_q == htoa_pkg::KEY_GONE);
  assign k_match = (key_rd_q == key_q);

  always_comb begin
    done_now  = 1'b0;
    found_now = 1'b0;
    empty_now = 1'b0;
    if (cmd_i.probe && rd_vld_q) begin
      if (is_scan) begin
        if (!k_empty && !k_gone) begin
          done_now  = 1'b1;
          found_now = 1'b1;
        end else if (rd_last_q) begin
          done_now = 1'b1;
        end
      end else begin
        if (k_empty) begin
          done_now  = 1'b1;
          empty_now = 1'b1;
        end else if (k_gone) begin
          done_now = rd_last_q;
        end else if (k_match) begin
          done_now  = 1'b1;
          found_now = 1'b1;
        end else if (rd_last_q) begin
          done_now = 1'b1;
        end
      end
    end
  end

  assign gone_now = cmd_i.probe && rd_vld_q && !is_scan && k_gone && !gone_ok_q;

  // Issue one slot read a cycle; the next address never waits on read data.
  assign issue      = cmd_i.probe && !issue_done_q && !done_now;
  assign issue_last = is_scan ? (idx_q == mask) : (step_q == cap);
  assign idx_next   = is_scan ? (idx_q + AW'(1)) : ((idx_q + step_q[AW-1:0]) & mask);

  assign out_free = !out_valid_q || !out_stall_i;
  assign fin      = cmd_i.finish && out_free;

  assign stat_o = '{kind: in_kind, done: done_now,
                    sweep_last: (clr_idx_q == {AW{1'b1}}), out_free: out_free};

  // Result and table update for the finished item.
  always_comb begin
    res        = '0;
    res.status = htoa_pkg::ST_MISS;
    used_d     = used_q;
    key_we     = cmd_i.sweep;
    key_wa     = clr_idx_q;
    key_wd     = htoa_pkg::KEY_EMPTY;
    dat_we     = 1'b0;
    dat_wa     = hit_at_q;
    ins_at     = gone_ok_q ? gone_at_q : empty_at_q;
    if (fin) begin
      if (rsv_q) begin
        res.status = htoa_pkg::ST_RESERVED;
      end else begin
        unique case (op_q)
          htoa_pkg::OP_FIND: begin
            if (hit_q) begin
              res.status     = htoa_pkg::ST_FOUND;
              res.data_out   = hit_data_q;
              res.slot_index = htoa_pkg::SLOT_W'(hit_at_q);
            end
          end
          htoa_pkg::OP_INSERT: begin
            if (hit_q) begin
              dat_we         = 1'b1;
              res.status     = htoa_pkg::ST_UPDATED;
              res.slot_index = htoa_pkg::SLOT_W'(hit_at_q);
            end else if (gone_ok_q || empty_ok_q) begin
              key_we         = 1'b1;
              key_wa         = ins_at;
              key_wd         = key_q;
              dat_we         = 1'b1;
              dat_wa         = ins_at;
              used_d         = (used_q == htoa_pkg::USED_MAX) ? used_q :
                               used_q + htoa_pkg::USED_W'(1);
              res.status     = htoa_pkg::ST_INSERTED;
              res.slot_index = htoa_pkg::SLOT_W'(ins_at);
            end else begin
              res.status = htoa_pkg::ST_FULL;
            end
          end
          htoa_pkg::OP_DELETE: begin
            if (hit_q) begin
              key_we         = 1'b1;
              key_wa         = hit_at_q;
              key_wd         = htoa_pkg::KEY_GONE;
              res.status     = htoa_pkg::ST_DELETED;
              res.slot_index = htoa_pkg::SLOT_W'(hit_at_q);
            end
          end
          htoa_pkg::OP_CLEAR: begin
            used_d     = '0;
            res.status = htoa_pkg::ST_CLEARED;
          end
          htoa_pkg::OP_SCAN: begin
            if (hit_q) begin
              res.status     = htoa_pkg::ST_FOUND;
              res.data_out   = hit_data_q;
              res.key_out    = hit_key_q;
              res.slot_index = htoa_pkg::SLOT_W'(hit_at_q);
            end
          end
          default: res.status = htoa_pkg::ST_MISS;
        endcase
      end
    end
    res.used_count = used_d;
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    if (issue) key_rd_q <= key_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (dat_we) data_mem[dat_wa] <= dat_q;
    if (issue) data_rd_q <= data_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q         <= '0;
      rsv_q        <= 1'b0;
      issue_done_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      gone_ok_q    <= 1'b0;
      empty_ok_q   <= 1'b0;
      clr_idx_q    <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= issue;
      if (cmd_i.accept) begin
        op_q         <= in_item_i.opcode;
        rsv_q        <= in_low && in_rsv;
        issue_done_q <= 1'b0;
        hit_q        <= 1'b0;
        gone_ok_q    <= 1'b0;
        empty_ok_q   <= 1'b0;
      end
      if (cmd_i.hash_c) issue_done_q <= 1'b0;
      if (issue && issue_last) issue_done_q <= 1'b1;
      if (found_now) hit_q <= 1'b1;
      if (gone_now) gone_ok_q <= 1'b1;
      if (empty_now) empty_ok_q <= 1'b1;
      if (cmd_i.sweep) clr_idx_q <= clr_idx_q + AW'(1);
      if (fin) begin
        used_q      <= used_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= in_item_i.key;
      dat_q <= in_item_i.entry_data;
      idx_q <= AW'(in_item_i.scan_from);
    end
    if (cmd_i.hash_a) h_q <= mix_a(key_q);
    if (cmd_i.hash_b) h_q <= mix_b(h_q);
    if (cmd_i.hash_c) begin
      idx_q  <= hc[AW-1:0] & mask;
      step_q <= CW'(1);
    end
    if (issue) begin
      idx_q     <= idx_next;
      step_q    <= step_q + CW'(1);
      rd_idx_q  <= idx_q;
      rd_last_q <= issue_last;
    end
    if (found_now) begin
      hit_at_q   <= rd_idx_q;
      hit_data_q <= data_rd_q;
      hit_key_q  <= key_rd_q;
    end
    if (gone_now) gone_at_q <= rd_idx_q;
    if (empty_now) empty_at_q <= rd_idx_q;
    if (fin) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/htoa_checker.sv =====
`include "hash_table_u32_open_addressing_core_macros.svh"

module htoa_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input htoa_pkg::out_item_t out_item_o
);

  logic in_xfer, out_held, rsv_out, clr_out, rsv_clean;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign rsv_out   = out_valid_o && (out_item_o.status == htoa_pkg::ST_RESERVED);
  assign clr_out   = out_valid_o && (out_item_o.status == htoa_pkg::ST_CLEARED);
  assign rsv_clean = (out_item_o.slot_index == '0) && (out_item_o.data_out == '0) &&
                     (out_item_o.key_out == '0);

  // one item at a time: an accepted transfer closes the input side
  `HTOA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_xfer, in_stall_o)

  `HTOA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_item_o))

  `HTOA_ASSERT_IMP(a_clear_zero_count, clk_i, rst_ni, clr_out, out_item_o.used_count == '0)

  // a rejected key touches nothing and reports no slot, data or key
  `HTOA_ASSERT_IMP(a_reserved_quiet, clk_i, rst_ni, rsv_out, rsv_clean)

endmodule

bind hash_table_u32_open_addressing_core htoa_checker u_htoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
